// ----- src/ple_pkg.sv -----
// Package for the positional list engine: request and status codes and the
// fixed field widths of the item channels. No dependencies.
`default_nettype none

package ple_pkg;

  // Field widths
  localparam int REQ_W = 2;
  localparam int POS_W = 6;
  localparam int VAL_W = 32;
  localparam int ST_W  = 2;
  localparam int CNT_W = 6;

  typedef logic [REQ_W-1:0] req_t;
  typedef logic [ST_W-1:0]  status_t;

  // Request codes
  localparam req_t REQ_INSERT = 2'd0;
  localparam req_t REQ_DELETE = 2'd1;
  localparam req_t REQ_DUMP   = 2'd2;

  // Status codes
  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_BADPOS = 2'd1;
  localparam status_t ST_FULL   = 2'd2;
  localparam status_t ST_EMPTY  = 2'd3;

endpackage

`default_nettype wire

// ----- src/ple_in_if.sv -----
// Request channel of the positional list engine: valid/ready plus one item.
// Depends on ple_pkg.
`default_nettype none

interface ple_in_if
  import ple_pkg::*;
();

  logic                    valid;
  logic                    ready;
  req_t                    req_type;
  logic [POS_W-1:0]        position;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, req_type, position, value, input ready);
  modport sink   (input valid, req_type, position, value, output ready);

endinterface

`default_nettype wire

// ----- src/ple_out_if.sv -----
// Result channel of the positional list engine: valid/ready plus one item.
// Depends on ple_pkg.
`default_nettype none

interface ple_out_if
  import ple_pkg::*;
();

  logic                    valid;
  logic                    ready;
  status_t                 status;
  logic signed [VAL_W-1:0] element;
  logic [CNT_W-1:0]        entry_count;
  logic                    last_result;

  modport source (output valid, status, element, entry_count, last_result, input ready);
  modport sink   (input valid, status, element, entry_count, last_result, output ready);

endinterface

`default_nettype wire

// ----- src/positional_list_engine.sv -----
// Positional list engine: ordered list held in one RAM, insert/delete by position, dump.
// Errors, full, empty dump: result in the cycle after the item is taken. Append and tail
// delete: no shifting, then S_FIN. Insert at p <= count, delete at p < count: shifting,
// one entry per cycle, then S_FIN. Dump: per entry S_DUMP_RD (waits for out_free), S_DUMP_CAP.
// One item at a time, set by the single read and write port of the list RAM.
// Reset (sync, active low) clears the count; RAM contents stay undefined, no clearing pass.
`default_nettype none

module positional_list_engine
  import ple_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ple_in_if.sink     in_ch,
  ple_out_if.source  out_ch
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int XW = ((POS_W > CW) ? POS_W : CW) + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_SHIFT,
    S_DEL_SHIFT,
    S_FIN,
    S_DUMP_RD,
    S_DUMP_CAP
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic [AW-1:0]           idx_r, idx_nxt;
  logic [AW-1:0]           stop_r, stop_nxt;
  logic [VAL_W-1:0]        val_r, val_nxt;
  logic                    ins_r, ins_nxt;
  logic                    wpend_r, wpend_nxt;
  logic [AW-1:0]           wpend_addr_r, wpend_addr_nxt;

  logic                    out_valid_r, out_valid_nxt;
  status_t                 out_status_r, out_status_nxt;
  logic [VAL_W-1:0]        out_element_r, out_element_nxt;
  logic [CNT_W-1:0]        out_count_r, out_count_nxt;
  logic                    out_last_r, out_last_nxt;

  logic                    in_fire;
  logic                    out_free;
  logic                    fin_go;
  logic [XW-1:0]           pos_x;
  logic [XW-1:0]           cnt_x;

  logic                    ram_we;
  logic [AW-1:0]           ram_wr_addr;
  logic [VAL_W-1:0]        ram_wr_data;
  logic [AW-1:0]           ram_rd_addr;
  logic [VAL_W-1:0]        ram_rd_data;

  // list storage
  ple_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_list_ram (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // handshakes
  assign out_free     = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE) && out_free;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign fin_go       = (state_r == S_FIN) && !wpend_r && out_free;

  assign pos_x = XW'(in_ch.position);
  assign cnt_x = XW'(count_r);

  // RAM write: pending shift write first, then the inserted value
  assign ram_we      = wpend_r || (fin_go && ins_r);
  assign ram_wr_addr = wpend_r ? wpend_addr_r : stop_r;
  assign ram_wr_data = wpend_r ? ram_rd_data : val_r;
  assign ram_rd_addr = idx_r;

  // result port
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.element     = out_element_r;
  assign out_ch.entry_count = out_count_r;
  assign out_ch.last_result = out_last_r;

  // sequencer
  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    idx_nxt         = idx_r;
    stop_nxt        = stop_r;
    val_nxt         = val_r;
    ins_nxt         = ins_r;
    wpend_nxt       = 1'b0;
    wpend_addr_nxt  = wpend_addr_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_status_nxt  = out_status_r;
    out_element_nxt = out_element_r;
    out_count_nxt   = out_count_r;
    out_last_nxt    = out_last_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          val_nxt         = in_ch.value;
          out_element_nxt = '0;
          out_count_nxt   = CNT_W'(count_r);
          out_last_nxt    = 1'b1;
          case (in_ch.req_type)
            REQ_INSERT: begin
              if (pos_x == '0 || pos_x > cnt_x + XW'(1)) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_BADPOS;
              end else if (count_r == CW'(CAPACITY)) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_FULL;
              end else begin
                ins_nxt  = 1'b1;
                stop_nxt = AW'(pos_x - XW'(1));
                idx_nxt  = AW'(cnt_x - XW'(1));
                // append needs no shift
                state_nxt = (pos_x == cnt_x + XW'(1)) ? S_FIN : S_INS_SHIFT;
              end
            end
            REQ_DELETE: begin
              if (pos_x == '0 || pos_x > cnt_x) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_BADPOS;
              end else begin
                ins_nxt  = 1'b0;
                idx_nxt  = AW'(pos_x);
                stop_nxt = AW'(cnt_x - XW'(1));
                // removing the tail needs no shift
                state_nxt = (pos_x == cnt_x) ? S_FIN : S_DEL_SHIFT;
              end
            end
            REQ_DUMP: begin
              if (count_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_EMPTY;
              end else begin
                idx_nxt   = '0;
                stop_nxt  = AW'(cnt_x - XW'(1));
                state_nxt = S_DUMP_RD;
              end
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_BADPOS;
            end
          endcase
        end
      end

      // read idx, write it back one place later, walking downwards
      S_INS_SHIFT: begin
        wpend_nxt      = 1'b1;
        wpend_addr_nxt = idx_r + AW'(1);
        if (idx_r == stop_r) begin
          state_nxt = S_FIN;
        end else begin
          idx_nxt = idx_r - AW'(1);
        end
      end

      // read idx, write it back one place earlier, walking upwards
      S_DEL_SHIFT: begin
        wpend_nxt      = 1'b1;
        wpend_addr_nxt = idx_r - AW'(1);
        if (idx_r == stop_r) begin
          state_nxt = S_FIN;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end

      // last shift write drains, then value write on insert, count update, result
      S_FIN: begin
        if (fin_go) begin
          count_nxt       = ins_r ? count_r + CW'(1) : count_r - CW'(1);
          out_valid_nxt   = 1'b1;
          out_status_nxt  = ST_OK;
          out_element_nxt = '0;
          out_count_nxt   = CNT_W'(count_nxt);
          out_last_nxt    = 1'b1;
          state_nxt       = S_IDLE;
        end
      end

      // read an entry once the result slot is free at this edge
      S_DUMP_RD: begin
        if (out_free) begin
          state_nxt = S_DUMP_CAP;
        end
      end

      // slot is empty here: load the read entry
      S_DUMP_CAP: begin
        out_valid_nxt   = 1'b1;
        out_status_nxt  = ST_OK;
        out_element_nxt = ram_rd_data;
        out_count_nxt   = CNT_W'(count_r);
        out_last_nxt    = (idx_r == stop_r);
        if (idx_r == stop_r) begin
          state_nxt = S_IDLE;
        end else begin
          idx_nxt   = idx_r + AW'(1);
          state_nxt = S_DUMP_RD;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      wpend_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      wpend_r     <= wpend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r         <= idx_nxt;
    stop_r        <= stop_nxt;
    val_r         <= val_nxt;
    ins_r         <= ins_nxt;
    wpend_addr_r  <= wpend_addr_nxt;
    out_status_r  <= out_status_nxt;
    out_element_r <= out_element_nxt;
    out_count_r   <= out_count_nxt;
    out_last_r    <= out_last_nxt;
  end

endmodule

`default_nettype wire

// ----- src/ple_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`default_nettype none

module ple_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ----- src/ple_checker.sv -----
// Port-level checks for the positional list engine, bound to the top level.
// Depends on ple_pkg and positional_list_engine.
`default_nettype none

module ple_checker
  import ple_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire status_t          out_status,
  input wire logic [VAL_W-1:0] out_element,
  input wire logic [CNT_W-1:0] out_entry_count,
  input wire logic             out_last_result
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_element) && $stable(out_entry_count) && $stable(out_last_result))
    else $error("stalled result changed");

  // a failed or empty item is a single result with no element
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_element == '0 && out_last_result)
    else $error("error result carries element or is not last");

  // full status only when the list holds CAPACITY entries
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_entry_count == CNT_W'(CAPACITY))
    else $error("full status with list not full");

  // no new item is taken while a dump is still running
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_result |=> !(in_valid && in_ready))
    else $error("item accepted during a dump");

endmodule

bind positional_list_engine ple_checker #(.CAPACITY(CAPACITY)) u_ple_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status      (out_ch.status),
  .out_element     (out_ch.element),
  .out_entry_count (out_ch.entry_count),
  .out_last_result (out_ch.last_result)
);

`default_nettype wire
